/* hdl/rrc_pkg.sv */
// Shared constants, types and helper functions of the rotated rectangle corner generator.
`default_nettype none

package rrc_pkg;

	localparam int COORD_BITS   = 24;
	localparam int TRIG_STAGES  = 16;
	localparam int ANGLE_BITS   = 18;
	localparam int LIMIT_BITS   = 12;
	localparam int LIMIT_RESET  = 26;

	localparam int FULL_TURN    = 92160;
	localparam int HALF_TURN    = 46080;
	localparam int QUARTER_TURN = 23040;

	localparam int WRAP_BITS    = 17;
	localparam int FOLD_BITS    = 16;
	localparam int MAG_BITS     = ANGLE_BITS;
	localparam int ANGLE_SHIFT  = 16;

	localparam int VEC_BITS     = 34;
	localparam int ZW           = 34;
	localparam int TRIG_BITS    = 27;
	localparam int TRIG_DROP    = 6;

	localparam int PROD_BITS    = COORD_BITS + TRIG_BITS;
	localparam int CTR_BITS     = COORD_BITS + 2;
	localparam int PLAIN_BITS   = COORD_BITS + 1;
	localparam int SUM_BITS     = PROD_BITS + 2;
	localparam int CTR_SHIFT    = 24;
	localparam int Q33_SHIFT    = 25;

	localparam int NUM_VERTS    = 4;
	localparam int VIDX_BITS    = 2;
	localparam logic [VIDX_BITS-1:0] VTX_NE = 2'd0;
	localparam logic [VIDX_BITS-1:0] VTX_NW = 2'd1;
	localparam logic [VIDX_BITS-1:0] VTX_SE = 2'd2;
	localparam logic [VIDX_BITS-1:0] VTX_SW = 2'd3;

	localparam int IN_DATA_BITS   = ((4 * COORD_BITS + ANGLE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_USER_BITS  = 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [TRIG_BITS-1:0]  trig_t;
	typedef logic signed [ZW-1:0]         zang_t;
	typedef logic signed [VEC_BITS-1:0]   vec_t;
	typedef logic signed [SUM_BITS-1:0]   sum_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic [NUM_VERTS-1:0][COORD_BITS-1:0] quad_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t w;
		coord_t h;
		logic   axis_aligned;
		logic   tex;
	} rect_t;

	localparam vec_t CORDIC_GAIN = VEC_BITS'(652032874);
	localparam sum_t COORD_MAX   = sum_t'((longint'(1) <<< (COORD_BITS - 1)) - 1);
	localparam sum_t COORD_MIN   = -COORD_MAX - sum_t'(1);

	// atan(2^-i) in units of 2^-24 degree
	function automatic zang_t atan_entry(input int i);
		zang_t r;
		unique case (i)
			0:  r = ZW'(754974720);
			1:  r = ZW'(445687602);
			2:  r = ZW'(235489088);
			3:  r = ZW'(119537938);
			4:  r = ZW'(60000934);
			5:  r = ZW'(30029717);
			6:  r = ZW'(15018523);
			7:  r = ZW'(7509720);
			8:  r = ZW'(3754917);
			9:  r = ZW'(1877466);
			10: r = ZW'(938734);
			11: r = ZW'(469367);
			12: r = ZW'(234684);
			13: r = ZW'(117342);
			14: r = ZW'(58671);
			15: r = ZW'(29335);
			16: r = ZW'(14668);
			17: r = ZW'(7334);
			18: r = ZW'(3667);
			19: r = ZW'(1833);
			20: r = ZW'(917);
			21: r = ZW'(458);
			22: r = ZW'(229);
			23: r = ZW'(115);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic coord_t sat_coord(input sum_t v);
		coord_t r;
		if (v > COORD_MAX) begin
			r = COORD_MAX[COORD_BITS-1:0];
		end else if (v < COORD_MIN) begin
			r = COORD_MIN[COORD_BITS-1:0];
		end else begin
			r = v[COORD_BITS-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hdl/rotated_rect_corner_gen_unit.sv */
// The pipeline takes an item every cycle unless the busy vertex stage stalls it
// (en low); the vertex stage sends one vertex per cycle while m_axis_tready is high,
// so each rectangle leaves as four vertices on the one output stream.
// The 16 CORDIC iterations each hold one register stage.
// Reset (arst_n low) clears all valid bits and sets small_angle_limit to 26.
`default_nettype none

module rotated_rect_corner_gen_unit import rrc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [LIMIT_BITS-1:0]    cfg_wr_data,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// corner_x, corner_y, rect_width, rect_height, rotation, zero pad
	input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
	// with_texture
	input  logic [0:0]               s_axis_tuser,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// vertex_x, vertex_y
	output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
	// tex_u, tex_v, textured_out
	output logic [OUT_USER_BITS-1:0] m_axis_tuser,
	output logic                     m_axis_tlast
);

	logic [LIMIT_BITS-1:0] limit_q;

	logic                  en;
	rect_t                 rect_in;
	logic signed [ANGLE_BITS-1:0] rot_in;

	logic                  prep_valid;
	zang_t                 prep_z;
	logic                  prep_flip;
	rect_t                 prep_rect;

	logic                  trig_valid;
	trig_t                 trig_cos;
	trig_t                 trig_sin;
	rect_t                 trig_rect;

	logic                  geom_valid;
	quad_t                 geom_vx;
	quad_t                 geom_vy;
	logic                  geom_tex;

	logic                  ser_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_BITS'(LIMIT_RESET);
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	assign en            = !geom_valid || ser_load;
	assign s_axis_tready = en;

	assign rect_in.x     = s_axis_tdata[COORD_BITS-1:0];
	assign rect_in.y     = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
	assign rect_in.w     = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
	assign rect_in.h     = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
	assign rect_in.axis_aligned = 1'b0;
	assign rect_in.tex   = s_axis_tuser[0];
	assign rot_in        = s_axis_tdata[4*COORD_BITS+ANGLE_BITS-1:4*COORD_BITS];

	rrc_angle_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.rotation  (rot_in),
		.limit     (limit_q),
		.rect_in   (rect_in),
		.out_valid (prep_valid),
		.z_out     (prep_z),
		.flip_out  (prep_flip),
		.rect_out  (prep_rect)
	);

	rrc_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (prep_valid),
		.z_in      (prep_z),
		.flip_in   (prep_flip),
		.rect_in   (prep_rect),
		.out_valid (trig_valid),
		.cos_out   (trig_cos),
		.sin_out   (trig_sin),
		.rect_out  (trig_rect)
	);

	rrc_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (trig_valid),
		.cos_in    (trig_cos),
		.sin_in    (trig_sin),
		.rect_in   (trig_rect),
		.out_valid (geom_valid),
		.vx_out    (geom_vx),
		.vy_out    (geom_vy),
		.tex_out   (geom_tex)
	);

	rrc_vertex_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (geom_valid),
		.vx_in     (geom_vx),
		.vy_in     (geom_vy),
		.tex_in    (geom_tex),
		.load      (ser_load),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output stage is empty");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
		else $error("vertex run broken before its last vertex");

	a_new_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tlast)
		else $error("vertex index not restarted after last vertex");

endmodule

`default_nettype wire

/* hdl/rrc_angle_prep.sv */
// Angle wrap, quadrant fold and small-angle test ahead of the CORDIC pipeline.
`default_nettype none

module rrc_angle_prep import rrc_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic signed [ANGLE_BITS-1:0] rotation,
	input  logic [LIMIT_BITS-1:0]        limit,
	input  rect_t                        rect_in,
	output logic                         out_valid,
	output zang_t                        z_out,
	output logic                         flip_out,
	output rect_t                        rect_out
);

	localparam int EXT_BITS = ANGLE_BITS + 2;

	logic signed [EXT_BITS-1:0]  a_ext;
	logic signed [EXT_BITS-1:0]  a_p1;
	logic signed [EXT_BITS-1:0]  a_p2;
	logic signed [EXT_BITS-1:0]  a_m1;
	logic signed [EXT_BITS-1:0]  wrap_c;
	logic [MAG_BITS-1:0]         mag_c;
	logic                        small_c;
	rect_t                       rect_c;

	logic                        valid_s1;
	logic [WRAP_BITS-1:0]        t_s1;
	rect_t                       rect_s1;

	logic signed [WRAP_BITS:0]   t_ext;
	logic signed [WRAP_BITS:0]   fold_c;
	logic                        over_c;
	logic                        flip_c;

	logic                        valid_s2;
	zang_t                       z_s2;
	logic                        flip_s2;
	rect_t                       rect_s2;

	always_comb begin
		a_ext = EXT_BITS'(rotation);
		a_p1  = a_ext + EXT_BITS'(FULL_TURN);
		a_p2  = a_p1 + EXT_BITS'(FULL_TURN);
		a_m1  = a_ext - EXT_BITS'(FULL_TURN);
		if (a_ext < 0) begin
			wrap_c = (a_p1 < 0) ? a_p2 : a_p1;
		end else if (a_ext >= EXT_BITS'(FULL_TURN)) begin
			wrap_c = a_m1;
		end else begin
			wrap_c = a_ext;
		end
		mag_c   = rotation[ANGLE_BITS-1] ? MAG_BITS'(-a_ext) : MAG_BITS'(a_ext);
		small_c = mag_c < MAG_BITS'(limit);
		rect_c  = rect_in;
		rect_c.axis_aligned = small_c;
	end

	always_comb begin
		t_ext  = $signed({1'b0, t_s1});
		over_c = t_ext > (WRAP_BITS + 1)'(QUARTER_TURN);
		flip_c = over_c && (t_ext < (WRAP_BITS + 1)'(FULL_TURN - QUARTER_TURN));
		if (flip_c) begin
			fold_c = t_ext - (WRAP_BITS + 1)'(HALF_TURN);
		end else if (over_c) begin
			fold_c = t_ext - (WRAP_BITS + 1)'(FULL_TURN);
		end else begin
			fold_c = t_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1          <= wrap_c[WRAP_BITS-1:0];
			rect_s1       <= rect_c;
			z_s2          <= zang_t'($signed(fold_c[FOLD_BITS-1:0])) <<< ANGLE_SHIFT;
			flip_s2       <= flip_c;
			rect_s2       <= rect_s1;
		end
	end

	assign out_valid = valid_s2;
	assign z_out     = z_s2;
	assign flip_out  = flip_s2;
	assign rect_out  = rect_s2;

endmodule

`default_nettype wire

/* hdl/rrc_cordic.sv */
// Rotation-mode CORDIC, one iteration per pipeline stage, with a rounding stage at the end.
`default_nettype none

module rrc_cordic import rrc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  zang_t z_in,
	input  logic  flip_in,
	input  rect_t rect_in,
	output logic  out_valid,
	output trig_t cos_out,
	output trig_t sin_out,
	output rect_t rect_out
);

	vec_t  x_s    [TRIG_STAGES];
	vec_t  y_s    [TRIG_STAGES];
	zang_t z_s    [TRIG_STAGES];
	logic  v_s    [TRIG_STAGES];
	logic  flip_s [TRIG_STAGES];
	rect_t rect_s [TRIG_STAGES];

	vec_t  xr_c;
	vec_t  yr_c;
	trig_t cr_c;
	trig_t sr_c;

	logic  valid_s;
	trig_t cos_s;
	trig_t sin_s;
	rect_t rect_fs;

	for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_iter
		vec_t  xi;
		vec_t  yi;
		vec_t  dx;
		vec_t  dy;
		zang_t zi;
		logic  vi;
		logic  fi;
		rect_t ri;

		if (i == 0) begin : g_first
			assign xi = CORDIC_GAIN;
			assign yi = '0;
			assign zi = z_in;
			assign vi = in_valid;
			assign fi = flip_in;
			assign ri = rect_in;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign vi = v_s[i-1];
			assign fi = flip_s[i-1];
			assign ri = rect_s[i-1];
		end

		assign dx = yi >>> i;
		assign dy = xi >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!zi[ZW-1]) begin
					x_s[i] <= xi - dx;
					y_s[i] <= yi + dy;
					z_s[i] <= zi - atan_entry(i);
				end else begin
					x_s[i] <= xi + dx;
					y_s[i] <= yi - dy;
					z_s[i] <= zi + atan_entry(i);
				end
				flip_s[i] <= fi;
				rect_s[i] <= ri;
			end
		end
	end

	always_comb begin
		xr_c = x_s[TRIG_STAGES-1] + (VEC_BITS'(1) <<< (TRIG_DROP - 1));
		yr_c = y_s[TRIG_STAGES-1] + (VEC_BITS'(1) <<< (TRIG_DROP - 1));
		cr_c = TRIG_BITS'(xr_c >>> TRIG_DROP);
		sr_c = TRIG_BITS'(yr_c >>> TRIG_DROP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (en) begin
			valid_s <= v_s[TRIG_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s   <= flip_s[TRIG_STAGES-1] ? -cr_c : cr_c;
			sin_s   <= flip_s[TRIG_STAGES-1] ? -sr_c : sr_c;
			rect_fs <= rect_s[TRIG_STAGES-1];
		end
	end

	assign out_valid = valid_s;
	assign cos_out   = cos_s;
	assign sin_out   = sin_s;
	assign rect_out  = rect_fs;

endmodule

`default_nettype wire

/* hdl/rrc_geom.sv */
// Corner geometry: products, centre sums, rounding, saturation and small-angle select.
`default_nettype none

module rrc_geom import rrc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  trig_t cos_in,
	input  trig_t sin_in,
	input  rect_t rect_in,
	output logic  out_valid,
	output quad_t vx_out,
	output quad_t vy_out,
	output logic  tex_out
);

	coord_t                      xi;
	coord_t                      yi;
	coord_t                      wi;
	coord_t                      hi;

	logic                        valid_s1;
	prod_t                       wc_s1;
	prod_t                       ws_s1;
	prod_t                       hc_s1;
	prod_t                       hs_s1;
	logic signed [CTR_BITS-1:0]  ctrx_s1;
	logic signed [CTR_BITS-1:0]  ctry_s1;
	logic signed [PLAIN_BITS-1:0] xw_s1;
	logic signed [PLAIN_BITS-1:0] yh_s1;
	rect_t                       rect_s1;

	sum_t                        cx_c;
	sum_t                        cy_c;

	logic                        valid_s2;
	sum_t                        pxm_s2;
	sum_t                        pxp_s2;
	sum_t                        pym_s2;
	sum_t                        pyp_s2;
	prod_t                       hs_s2;
	prod_t                       hc_s2;
	logic signed [PLAIN_BITS-1:0] xw_s2;
	logic signed [PLAIN_BITS-1:0] yh_s2;
	rect_t                       rect_s2;

	logic                        valid_s3;
	sum_t                        vx_s3 [NUM_VERTS];
	sum_t                        vy_s3 [NUM_VERTS];
	logic signed [PLAIN_BITS-1:0] xw_s3;
	logic signed [PLAIN_BITS-1:0] yh_s3;
	rect_t                       rect_s3;

	coord_t                      xw_sat;
	coord_t                      yh_sat;
	quad_t                       vx_c;
	quad_t                       vy_c;

	logic                        valid_s4;
	quad_t                       vx_s4;
	quad_t                       vy_s4;
	logic                        tex_s4;

	assign xi = rect_in.x;
	assign yi = rect_in.y;
	assign wi = rect_in.w;
	assign hi = rect_in.h;

	assign cx_c = sum_t'(ctrx_s1) <<< CTR_SHIFT;
	assign cy_c = sum_t'(ctry_s1) <<< CTR_SHIFT;

	always_comb begin
		xw_sat = sat_coord(sum_t'(xw_s3));
		yh_sat = sat_coord(sum_t'(yh_s3));
		if (rect_s3.axis_aligned) begin
			vx_c[VTX_NE] = rect_s3.x;
			vx_c[VTX_NW] = xw_sat;
			vx_c[VTX_SE] = rect_s3.x;
			vx_c[VTX_SW] = xw_sat;
			vy_c[VTX_NE] = rect_s3.y;
			vy_c[VTX_NW] = rect_s3.y;
			vy_c[VTX_SE] = yh_sat;
			vy_c[VTX_SW] = yh_sat;
		end else begin
			vx_c[VTX_NE] = sat_coord(vx_s3[VTX_NE] >>> Q33_SHIFT);
			vx_c[VTX_NW] = sat_coord(vx_s3[VTX_NW] >>> Q33_SHIFT);
			vx_c[VTX_SE] = sat_coord(vx_s3[VTX_SE] >>> Q33_SHIFT);
			vx_c[VTX_SW] = sat_coord(vx_s3[VTX_SW] >>> Q33_SHIFT);
			vy_c[VTX_NE] = sat_coord(vy_s3[VTX_NE] >>> Q33_SHIFT);
			vy_c[VTX_NW] = sat_coord(vy_s3[VTX_NW] >>> Q33_SHIFT);
			vy_c[VTX_SE] = sat_coord(vy_s3[VTX_SE] >>> Q33_SHIFT);
			vy_c[VTX_SW] = sat_coord(vy_s3[VTX_SW] >>> Q33_SHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wc_s1   <= wi * cos_in;
			ws_s1   <= wi * sin_in;
			hc_s1   <= hi * cos_in;
			hs_s1   <= hi * sin_in;
			ctrx_s1 <= $signed({xi[COORD_BITS-1], xi, 1'b1}) + CTR_BITS'(wi);
			ctry_s1 <= $signed({yi[COORD_BITS-1], yi, 1'b1}) + CTR_BITS'(hi);
			xw_s1   <= PLAIN_BITS'(xi) + PLAIN_BITS'(wi);
			yh_s1   <= PLAIN_BITS'(yi) + PLAIN_BITS'(hi);
			rect_s1 <= rect_in;

			pxm_s2  <= cx_c - sum_t'(wc_s1);
			pxp_s2  <= cx_c + sum_t'(wc_s1);
			pym_s2  <= cy_c - sum_t'(ws_s1);
			pyp_s2  <= cy_c + sum_t'(ws_s1);
			hs_s2   <= hs_s1;
			hc_s2   <= hc_s1;
			xw_s2   <= xw_s1;
			yh_s2   <= yh_s1;
			rect_s2 <= rect_s1;

			vx_s3[VTX_NE] <= pxm_s2 + sum_t'(hs_s2);
			vy_s3[VTX_NE] <= pym_s2 - sum_t'(hc_s2);
			vx_s3[VTX_NW] <= pxp_s2 + sum_t'(hs_s2);
			vy_s3[VTX_NW] <= pyp_s2 - sum_t'(hc_s2);
			vx_s3[VTX_SE] <= pxm_s2 - sum_t'(hs_s2);
			vy_s3[VTX_SE] <= pym_s2 + sum_t'(hc_s2);
			vx_s3[VTX_SW] <= pxp_s2 - sum_t'(hs_s2);
			vy_s3[VTX_SW] <= pyp_s2 + sum_t'(hc_s2);
			xw_s3   <= xw_s2;
			yh_s3   <= yh_s2;
			rect_s3 <= rect_s2;

			vx_s4   <= vx_c;
			vy_s4   <= vy_c;
			tex_s4  <= rect_s3.tex;
		end
	end

	assign out_valid = valid_s4;
	assign vx_out    = vx_s4;
	assign vy_out    = vy_s4;
	assign tex_out   = tex_s4;

endmodule

`default_nettype wire

/* hdl/rrc_vertex_ser.sv */
// Output register that holds one rectangle and sends its four vertices in strip order.
`default_nettype none

module rrc_vertex_ser import rrc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  quad_t                    vx_in,
	input  quad_t                    vy_in,
	input  logic                     tex_in,
	output logic                     load,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [OUT_DATA_BITS-1:0] out_data,
	output logic [OUT_USER_BITS-1:0] out_user,
	output logic                     out_last
);

	logic                 valid_q;
	logic [VIDX_BITS-1:0] idx_q;
	quad_t                vx_q;
	quad_t                vy_q;
	logic                 tex_q;

	assign load = !valid_q || (out_ready && idx_q == VTX_SW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= VTX_NE;
		end else if (load) begin
			valid_q <= in_valid;
			idx_q   <= VTX_NE;
		end else if (out_ready) begin
			idx_q   <= idx_q + VIDX_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			vx_q  <= vx_in;
			vy_q  <= vy_in;
			tex_q <= tex_in;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = OUT_DATA_BITS'({vy_q[idx_q], vx_q[idx_q]});
	assign out_user  = {tex_q, tex_q & idx_q[1], tex_q & idx_q[0]};
	assign out_last  = idx_q == VTX_SW;

endmodule

`default_nettype wire
